// ----- hdl/pli_pkg.sv -----
// package for the positional list block: widths, operation and status codes
// and the command bundle broadcast to the storage cells
// no dependencies
package pli_pkg;

  localparam int unsigned CAPACITY_DEF = 16;
  localparam int unsigned OP_W         = 3;
  localparam int unsigned POS_W        = 8;
  localparam int unsigned VALUE_W      = 32;
  localparam int unsigned STATUS_W     = 2;
  localparam int unsigned COUNT_W      = 5;
  // cell index width, covers every position up to the largest capacity
  localparam int unsigned IDX_W        = 9;
  localparam int unsigned IN_DATA_W    = 40;
  localparam int unsigned OUT_DATA_W   = 40;

  typedef enum logic [OP_W-1:0] {
    OP_INS_FRONT = 3'd0,
    OP_INS_BACK  = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FRONT = 3'd3,
    OP_DEL_BACK  = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_READ      = 3'd6
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK        = 2'd0,
    STAT_EMPTY     = 2'd1,
    STAT_BAD_INDEX = 2'd2,
    STAT_FULL      = 2'd3
  } status_e;

  // one command per cycle, seen by every cell of the row
  typedef struct packed {
    logic               ins;
    logic               del;
    logic [IDX_W-1:0]   pos;
    logic [VALUE_W-1:0] value;
  } cell_cmd_t;

endpackage

// ----- hdl/positional_list_insert_delete_top.sv -----
// top level of the positional list: row of shifting cells, count register,
// operation decode and a registered result stage
// depends on pli_pkg and pli_cell
//
// channel   dir  handshake              payload
// s_axis    in   s_axis_tvalid/tready   tuser: op, tdata: position, value
// m_axis    out  m_axis_tvalid/tready   tuser: status, tdata: count, read_value
//
// every cell shifts or loads in the accept cycle and the result is registered in
// the same edge, so one item per clock is sustained while m_axis_tready is high
// reset clears the count and the result valid, cell contents stay undefined
// s_axis_tready drops only while a result is held and m_axis_tready is low
module positional_list_insert_delete_top #(
  parameter int unsigned CAPACITY = pli_pkg::CAPACITY_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [7:0] position, [39:8] value
  input  logic [pli_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // [2:0] op
  input  logic [pli_pkg::OP_W-1:0]        s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [4:0] count, [36:5] read_value, [39:37] zero
  output logic [pli_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // [1:0] status
  output logic [pli_pkg::STATUS_W-1:0]    m_axis_tuser
);

  localparam int unsigned CntW = $clog2(CAPACITY + 1);
  localparam logic [pli_pkg::IDX_W-1:0] CapV = pli_pkg::IDX_W'(CAPACITY);
  localparam int unsigned PadW =
    pli_pkg::OUT_DATA_W - pli_pkg::COUNT_W - pli_pkg::VALUE_W;

  // input unpacking
  logic                          in_xfer;
  pli_pkg::op_e                  op;
  logic [pli_pkg::IDX_W-1:0]     pos_w;
  logic [pli_pkg::VALUE_W-1:0]   in_value;

  assign in_xfer  = s_axis_tvalid && s_axis_tready;
  assign op       = pli_pkg::op_e'(s_axis_tuser);
  assign pos_w    = pli_pkg::IDX_W'(s_axis_tdata[pli_pkg::POS_W-1:0]);
  assign in_value = s_axis_tdata[pli_pkg::POS_W +: pli_pkg::VALUE_W];

  // entry count
  logic [CntW-1:0]            cnt_q, cnt_d;
  logic [pli_pkg::IDX_W-1:0]  cnt_w;
  logic                       full, empty;

  assign cnt_w = pli_pkg::IDX_W'(cnt_q);
  assign full  = (cnt_w == CapV);
  assign empty = (cnt_q == '0);

  // result register
  logic                           out_valid_q;
  pli_pkg::status_e               status_q, status_d;
  logic [pli_pkg::COUNT_W-1:0]    count_q, count_d;
  logic [pli_pkg::VALUE_W-1:0]    rd_q, rd_d;

  // the next item may enter whenever the result slot is free or draining
  assign s_axis_tready = !out_valid_q || m_axis_tready;

  // cell row
  pli_pkg::cell_cmd_t            cmd;
  logic [pli_pkg::VALUE_W-1:0]   cell_val [CAPACITY];
  logic [pli_pkg::VALUE_W-1:0]   cell_rd  [CAPACITY];
  logic [pli_pkg::VALUE_W-1:0]   rd_bus;

  for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
    // the ends feed back their own value; the first cell's is never selected, the last keeps its value on a delete
    pli_cell #(
      .Idx (g)
    ) u_cell (
      .clk_i   (clk_i),
      .cmd_i   (cmd),
      .left_i  (cell_val[(g == 0) ? 0 : g - 1]),
      .right_i (cell_val[(g == CAPACITY - 1) ? g : g + 1]),
      .value_o (cell_val[g]),
      .rd_o    (cell_rd[g])
    );
  end

  // only the addressed cell drives a nonzero value onto the read bus
  always_comb begin
    rd_bus = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      rd_bus = rd_bus | cell_rd[i];
    end
  end

  // operation decode
  logic                       do_ins, do_del, do_read;
  logic [pli_pkg::IDX_W-1:0]  tgt_pos;

  always_comb begin
    status_d = pli_pkg::STAT_OK;
    do_ins   = 1'b0;
    do_del   = 1'b0;
    do_read  = 1'b0;
    tgt_pos  = pos_w;
    unique case (op)
      pli_pkg::OP_INS_FRONT, pli_pkg::OP_INS_BACK, pli_pkg::OP_INS_AT: begin
        // full is checked before the position
        priority if (full) begin
          status_d = pli_pkg::STAT_FULL;
        end else if (op == pli_pkg::OP_INS_FRONT || empty) begin
          do_ins  = 1'b1;
          tgt_pos = (op == pli_pkg::OP_INS_BACK) ? cnt_w : '0;
        end else if (op == pli_pkg::OP_INS_BACK) begin
          do_ins  = 1'b1;
          tgt_pos = cnt_w;
        end else if (pos_w > cnt_w) begin
          status_d = pli_pkg::STAT_BAD_INDEX;
        end else begin
          do_ins = 1'b1;
        end
      end
      pli_pkg::OP_DEL_FRONT, pli_pkg::OP_DEL_BACK, pli_pkg::OP_DEL_AT,
      pli_pkg::OP_READ: begin
        priority if (empty) begin
          status_d = pli_pkg::STAT_EMPTY;
        end else if (op == pli_pkg::OP_DEL_FRONT) begin
          do_del  = 1'b1;
          tgt_pos = '0;
        end else if (op == pli_pkg::OP_DEL_BACK) begin
          do_del  = 1'b1;
          tgt_pos = cnt_w - 1'b1;
        end else if (pos_w >= cnt_w) begin
          status_d = pli_pkg::STAT_BAD_INDEX;
        end else if (op == pli_pkg::OP_DEL_AT) begin
          do_del = 1'b1;
        end else begin
          do_read = 1'b1;
        end
      end
      default: begin
        // unused op code: no change, ok status
      end
    endcase
  end

  // the row only moves on an accepted transfer
  assign cmd.ins   = do_ins && in_xfer;
  assign cmd.del   = do_del && in_xfer;
  assign cmd.pos   = tgt_pos;
  assign cmd.value = in_value;

  logic [pli_pkg::IDX_W-1:0] cnt_next_w;

  always_comb begin
    cnt_d = cnt_q;
    if (cmd.ins) begin
      cnt_d = cnt_q + 1'b1;
    end else if (cmd.del) begin
      cnt_d = cnt_q - 1'b1;
    end
    cnt_next_w = pli_pkg::IDX_W'(cnt_d);
    count_d    = cnt_next_w[pli_pkg::COUNT_W-1:0];
    rd_d       = do_read ? rd_bus : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (in_xfer) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // result payload, loaded on every accepted transfer
  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      status_q <= status_d;
      count_q  <= count_d;
      rd_q     <= rd_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = status_q;
  assign m_axis_tdata  = {{PadW{1'b0}}, rd_q, count_q};

`ifndef NO_ASSERTIONS
  // the count never passes the capacity
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pli_pkg::IDX_W'(cnt_q) <= CapV)
    else $error("entry count above capacity");

  // an accepted insert that is allowed grows the list by exactly one
  a_ins_grow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd.ins |=> (cnt_q == $past(cnt_q) + 1'b1))
    else $error("insert did not grow the list by one");

  // a failing operation leaves the count alone
  a_fail_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_xfer && status_d != pli_pkg::STAT_OK) |=> $stable(cnt_q))
    else $error("failed operation changed the count");

  // a failed result never carries read data
  a_rd_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser != pli_pkg::STAT_OK) |-> (rd_q == '0))
    else $error("read data on a failed result");
`endif

endmodule

// ----- hdl/pli_cell.sv -----
// one storage cell of the list row: holds one entry and shifts toward
// either neighbor on insert or delete
// depends on pli_pkg
module pli_cell #(
  parameter int unsigned Idx = 0
) (
  input  logic                         clk_i,
  input  pli_pkg::cell_cmd_t           cmd_i,
  input  logic [pli_pkg::VALUE_W-1:0]  left_i,
  input  logic [pli_pkg::VALUE_W-1:0]  right_i,
  output logic [pli_pkg::VALUE_W-1:0]  value_o,
  output logic [pli_pkg::VALUE_W-1:0]  rd_o
);

  localparam logic [pli_pkg::IDX_W-1:0] IdxV = pli_pkg::IDX_W'(Idx);

  logic [pli_pkg::VALUE_W-1:0] value_q, value_d;
  logic                        hit, above;

  assign hit   = (cmd_i.pos == IdxV);
  assign above = (IdxV > cmd_i.pos);

  always_comb begin
    value_d = value_q;
    if (cmd_i.ins) begin
      if (above) begin
        value_d = left_i;
      end else if (hit) begin
        value_d = cmd_i.value;
      end
    end else if (cmd_i.del) begin
      if (above || hit) begin
        value_d = right_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    value_q <= value_d;
  end

  assign value_o = value_q;
  // contribution to the read bus, only the addressed cell drives it
  assign rd_o    = hit ? value_q : '0;

endmodule
